[rtl/chip8ie_pkg.sv]
// Shared types and constants for the CHIP-8 instruction execute block.
`default_nettype none

package chip8ie_pkg;

    localparam int ADDR_W          = 12;
    localparam int WORD_W          = 16;
    localparam int DATA_W          = 8;
    localparam int REG_NUM_W       = 4;
    localparam int NUM_REGS        = 16;
    localparam int KEYS_W          = 16;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [ADDR_W-1:0] PROG_START = 12'h200;
    localparam logic [ADDR_W-1:0] STEP_BYTES = 12'h002;

    localparam logic [WORD_W-1:0] WORD_HALT   = 16'h0000;
    localparam logic [WORD_W-1:0] WORD_CLEAR  = 16'h00E0;
    localparam logic [WORD_W-1:0] WORD_RETURN = 16'h00EE;

    localparam logic [DATA_W-1:0] KEY_SKIP_PRESSED  = 8'h9E;
    localparam logic [DATA_W-1:0] KEY_SKIP_RELEASED = 8'hA1;

    typedef enum logic [3:0] {
        OP_SYS       = 4'h0,
        OP_JUMP      = 4'h1,
        OP_CALL      = 4'h2,
        OP_SKEQ_IMM  = 4'h3,
        OP_SKNE_IMM  = 4'h4,
        OP_SKEQ_REG  = 4'h5,
        OP_LOAD_IMM  = 4'h6,
        OP_ADD_IMM   = 4'h7,
        OP_ALU       = 4'h8,
        OP_SKNE_REG  = 4'h9,
        OP_SET_INDEX = 4'hA,
        OP_JUMP_V0   = 4'hB,
        OP_RANDOM    = 4'hC,
        OP_DRAW      = 4'hD,
        OP_KEY       = 4'hE,
        OP_MISC      = 4'hF
    } t_opcode;

    typedef enum logic [3:0] {
        ALU_MOV  = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } t_alu_op;

endpackage

`default_nettype wire

[rtl/chip8_instruction_execute.sv]
// Top level of the CHIP-8 instruction execute block.
`default_nettype none

// Executes one CHIP-8 instruction word per transaction.
// Input channel: i_in_valid / o_in_stall carry the instruction word, a random
// byte and the key bitmap. Output channel: o_out_valid / i_out_stall carry the
// next fetch address, the index register, the data register write (if any)
// and the clear and halt flags. One result per instruction.
// An accepted instruction is decoded and executed from the input register and
// its result is loaded into the output register. Throughput is one
// instruction per cycle while the receiver does not stall; the limit is the
// single execute step between the input and output registers, which also
// updates the program counter, index register, register file and return
// stack so the next instruction sees them.
// The register file is a 16-entry memory read synchronously at accept time
// (with bypass from the instruction being executed); the return stack is a
// memory whose top entry is kept prefetched in a register.
// Reset: PC goes to 0x200, index and stack pointer to zero, all data
// registers read as zero (per-entry valid bits), both channels empty.
// When the receiver stalls, the result holds; the input register holds one more
// instruction and o_in_stall rises only when both stages are full.
module chip8_instruction_execute
    import chip8ie_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [WORD_W-1:0]    i_instr_word,
    input  wire logic [DATA_W-1:0]    i_random_byte,
    input  wire logic [KEYS_W-1:0]    i_keys_down,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [ADDR_W-1:0]         o_fetch_address,
    output logic [ADDR_W-1:0]         o_index_value,
    output logic                      o_reg_write_valid,
    output logic [REG_NUM_W-1:0]      o_reg_write_number,
    output logic [DATA_W-1:0]         o_reg_write_data,
    output logic                      o_clear_screen,
    output logic                      o_halted
);

    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    // ---------------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic out_free;
    logic in_accept;
    logic exec;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------
    logic [WORD_W-1:0] r_instr;
    logic [DATA_W-1:0] r_random;
    logic [KEYS_W-1:0] r_keys;

    // ---------------------------------------------------------------------
    // Architectural state
    // ---------------------------------------------------------------------
    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] r_index;
    logic [SP_W-1:0]   r_sp;

    logic [DATA_W-1:0] regfile [NUM_REGS];
    logic [NUM_REGS-1:0] r_reg_written;
    logic [DATA_W-1:0] r_vx;
    logic [DATA_W-1:0] r_vy;
    logic [DATA_W-1:0] r_v0;

    logic [ADDR_W-1:0] stack_mem [STACK_DEPTH];
    logic [ADDR_W-1:0] r_stack_top;

    // ---------------------------------------------------------------------
    // Decode and execute
    // ---------------------------------------------------------------------
    t_opcode           opcode;
    t_alu_op           alu_op;
    logic [REG_NUM_W-1:0] x_num;
    logic [ADDR_W-1:0] nnn;
    logic [DATA_W-1:0] kk;
    logic [ADDR_W-1:0] pc_adv;
    logic              key_hit;
    logic              is_call;
    logic              is_return;
    logic              skip;
    logic              wr;
    logic [DATA_W-1:0] wdata;
    logic              set_index;
    logic [ADDR_W-1:0] n_pc;
    logic [SP_W-1:0]   n_sp;
    logic [SP_W-1:0]   sp_inc;
    logic [SP_W-1:0]   sp_dec;
    logic [SP_W-1:0]   top_addr;

    assign opcode = t_opcode'(r_instr[15:12]);
    assign alu_op = t_alu_op'(r_instr[3:0]);
    assign x_num  = r_instr[11:8];
    assign nnn    = r_instr[11:0];
    assign kk     = r_instr[7:0];
    assign pc_adv = r_pc + STEP_BYTES;

    // Key numbers of 16 or more count as not pressed.
    assign key_hit = (r_vx[7:4] == 4'h0) && r_keys[r_vx[3:0]];

    assign is_call   = (opcode == OP_CALL);
    assign is_return = (r_instr == WORD_RETURN);

    assign sp_inc = (r_sp == SP_LAST) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SP_LAST : r_sp - 1'b1;

    always_comb begin
        skip      = 1'b0;
        wr        = 1'b0;
        wdata     = '0;
        set_index = 1'b0;
        n_pc      = pc_adv;
        n_sp      = r_sp;
        case (opcode)
            OP_SYS: begin
                if (is_return) begin
                    n_sp = sp_dec;
                    n_pc = r_stack_top;
                end
            end
            OP_JUMP: begin
                n_pc = nnn;
            end
            OP_CALL: begin
                n_sp = sp_inc;
                n_pc = nnn;
            end
            OP_SKEQ_IMM: skip = (r_vx == kk);
            OP_SKNE_IMM: skip = (r_vx != kk);
            OP_SKEQ_REG: skip = (r_vx == r_vy);
            OP_SKNE_REG: skip = (r_vx != r_vy);
            OP_LOAD_IMM: begin
                wr    = 1'b1;
                wdata = kk;
            end
            OP_ADD_IMM: begin
                wr    = 1'b1;
                wdata = r_vx + kk;
            end
            OP_ALU: begin
                wr = 1'b1;
                case (alu_op)
                    ALU_MOV:  wdata = r_vy;
                    ALU_OR:   wdata = r_vx | r_vy;
                    ALU_AND:  wdata = r_vx & r_vy;
                    ALU_XOR:  wdata = r_vx ^ r_vy;
                    ALU_ADD:  wdata = r_vx + r_vy;
                    ALU_SUB:  wdata = r_vx - r_vy;
                    ALU_SUBN: wdata = r_vy - r_vx;
                    ALU_SHR:  wdata = (r_vy[7:3] != '0) ? '0 : r_vx >> r_vy[2:0];
                    ALU_SHL:  wdata = (r_vy[7:3] != '0) ? '0 : r_vx << r_vy[2:0];
                    default:  wr    = 1'b0;
                endcase
            end
            OP_SET_INDEX: set_index = 1'b1;
            OP_JUMP_V0: begin
                n_pc = {4'h0, r_v0} + nnn;
            end
            OP_RANDOM: begin
                wr    = 1'b1;
                wdata = r_random & kk;
            end
            OP_KEY: begin
                if (kk == KEY_SKIP_PRESSED) begin
                    skip = key_hit;
                end else if (kk == KEY_SKIP_RELEASED) begin
                    skip = !key_hit;
                end
            end
            default: begin
                // Draw and the Fxnn group are no-ops here.
            end
        endcase
        if (skip) begin
            n_pc = pc_adv + STEP_BYTES;
        end
    end

    // Top entry after this instruction sits just below the new pointer.
    assign top_addr = (n_sp == '0) ? SP_LAST : n_sp - 1'b1;

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_pc          <= PROG_START;
            r_index       <= '0;
            r_sp          <= '0;
            r_reg_written <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (exec) begin
                r_in_valid <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (exec) begin
                r_pc <= n_pc;
                r_sp <= n_sp;
                if (set_index) begin
                    r_index <= nnn;
                end
                if (wr) begin
                    r_reg_written[x_num] <= 1'b1;
                end
            end
        end
    end

    // Capture the next instruction and its operands.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_instr  <= i_instr_word;
            r_random <= i_random_byte;
            r_keys   <= i_keys_down;
        end
    end

    // ---------------------------------------------------------------------
    // Register file: write on execute, read on accept with bypass from the
    // instruction retiring in the same cycle. Unwritten entries read zero.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (exec && wr) begin
            regfile[x_num] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (exec && wr && (x_num == i_instr_word[11:8])) begin
                r_vx <= wdata;
            end else begin
                r_vx <= r_reg_written[i_instr_word[11:8]] ? regfile[i_instr_word[11:8]] : '0;
            end
            if (exec && wr && (x_num == i_instr_word[7:4])) begin
                r_vy <= wdata;
            end else begin
                r_vy <= r_reg_written[i_instr_word[7:4]] ? regfile[i_instr_word[7:4]] : '0;
            end
            if (exec && wr && (x_num == '0)) begin
                r_v0 <= wdata;
            end else begin
                r_v0 <= r_reg_written[0] ? regfile[0] : '0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Return stack: push writes the advanced PC; the top entry is re-read
    // every cycle from the pointer that follows this instruction.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (exec && is_call) begin
            stack_mem[r_sp] <= pc_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && is_call) begin
            r_stack_top <= pc_adv;
        end else begin
            r_stack_top <= stack_mem[exec ? top_addr : sp_dec];
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (exec) begin
            o_fetch_address    <= n_pc;
            o_index_value      <= set_index ? nnn : r_index;
            o_reg_write_valid  <= wr;
            o_reg_write_number <= wr ? x_num : '0;
            o_reg_write_data   <= wr ? wdata : '0;
            o_clear_screen     <= (r_instr == WORD_CLEAR);
            o_halted           <= (r_instr == WORD_HALT);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/chip8ie_checker.sv]
// Port-level checker for the CHIP-8 instruction execute block, with its bind.
`default_nettype none

module chip8ie_checker
    import chip8ie_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [ADDR_W-1:0]    o_fetch_address,
    input wire logic                 o_reg_write_valid,
    input wire logic [REG_NUM_W-1:0] o_reg_write_number,
    input wire logic [DATA_W-1:0]    o_reg_write_data,
    input wire logic                 o_clear_screen,
    input wire logic                 o_halted
);

    // Output channel is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_fetch_address)
            && $stable(o_reg_write_data) && $stable(o_reg_write_valid))
        else $error("stalled result changed");

    // Input backpressure only when the result stage is full and stalled.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while result stage could drain");

    // No register write fields without a write.
    a_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reg_write_valid |->
            o_reg_write_number == '0 && o_reg_write_data == '0)
        else $error("write fields set without a register write");

    // Halt and clear words write nothing and are never both set.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_halted || o_clear_screen) |->
            !o_reg_write_valid && !(o_halted && o_clear_screen))
        else $error("halt or clear result with a register write");

endmodule

bind chip8_instruction_execute chip8ie_checker u_chip8ie_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_fetch_address    (o_fetch_address),
    .o_reg_write_valid  (o_reg_write_valid),
    .o_reg_write_number (o_reg_write_number),
    .o_reg_write_data   (o_reg_write_data),
    .o_clear_screen     (o_clear_screen),
    .o_halted           (o_halted)
);

`default_nettype wire
